@@ hw/rtl/slxd_pkg.sv @@
// Shared types and constants for the sync/length/XOR message deframer.
`timescale 1ns / 1ps

package slxd_pkg;

  // Payload buffer size and the widths that follow from it.
  localparam int MAX_PAYLOAD = 16;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);

  // Command queue between the parser and the result sequencer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Payload bursts pending in the back end; queue entries plus the one being sent.
  localparam int PEND_W      = $clog2(QUEUE_DEPTH + 2);

  localparam logic [7:0] SYNC_RESET = 8'hA4;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_ID,
    PH_DATA,
    PH_CHK
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SYNC = 2'd1,
    ST_CSUM = 2'd2,
    ST_LEN  = 2'd3
  } status_t;

  // One command for the back end: a single report, or a payload burst.
  typedef struct packed {
    status_t          status;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] payload_len;
    logic             burst;
  } cmd_t;

  // Write port into the payload buffer.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage

@@ hw/rtl/slxd_front.sv @@
// Frame parser: hunts for sync, checks length and checksum, fills the payload buffer.
`timescale 1ns / 1ps

module slxd_front
  import slxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  logic       burst_done,
  output store_wr_t  store_wr
);

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  frame_len, frame_len_next;
  logic [7:0]        frame_id, frame_id_next;
  logic [LEN_W-1:0]  byte_count, byte_count_next;
  logic [7:0]        running_xor, running_xor_next;
  logic              sync_error_sent, sync_error_sent_next;
  logic [7:0]        sync_value;
  logic [PEND_W-1:0] pending, pending_next;
  logic              accept;
  logic [LEN_W-1:0]  count_inc;

  assign cfg_ready = 1'b1;

  // Data bytes wait while an earlier payload is still queued or being sent.
  assign in_ready = !q_full && !(phase == PH_DATA && pending != '0);
  assign accept   = in_valid && in_ready;
  assign count_inc = byte_count + LEN_W'(1);

  // Sync value register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_value <= cfg_data;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      frame_len       <= '0;
      frame_id        <= '0;
      byte_count      <= '0;
      running_xor     <= '0;
      sync_error_sent <= 1'b0;
      pending         <= '0;
    end else begin
      phase           <= phase_next;
      frame_len       <= frame_len_next;
      frame_id        <= frame_id_next;
      byte_count      <= byte_count_next;
      running_xor     <= running_xor_next;
      sync_error_sent <= sync_error_sent_next;
      pending         <= pending_next;
    end
  end

  // Next state, queue commands and buffer writes for one accepted beat.
  always_comb begin
    phase_next           = phase;
    frame_len_next       = frame_len;
    frame_id_next        = frame_id;
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    sync_error_sent_next = sync_error_sent;
    q_push               = 1'b0;
    q_cmd                = '0;
    store_wr             = '0;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == sync_value) begin
            sync_error_sent_next = 1'b0;
            running_xor_next     = rx_byte;
            byte_count_next      = '0;
            phase_next           = PH_LEN;
          end else if (!sync_error_sent) begin
            sync_error_sent_next = 1'b1;
            q_push               = 1'b1;
            q_cmd.status         = ST_SYNC;
          end
        end
        PH_LEN: begin
          running_xor_next = running_xor ^ rx_byte;
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            q_push       = 1'b1;
            q_cmd.status = ST_LEN;
            phase_next   = PH_HUNT;
          end else begin
            frame_len_next = rx_byte[LEN_W-1:0];
            phase_next     = PH_ID;
          end
        end
        PH_ID: begin
          frame_id_next    = rx_byte;
          running_xor_next = running_xor ^ rx_byte;
          byte_count_next  = '0;
          phase_next       = (frame_len == '0) ? PH_CHK : PH_DATA;
        end
        PH_DATA: begin
          store_wr.en      = 1'b1;
          store_wr.addr    = byte_count[IDX_W-1:0];
          store_wr.data    = rx_byte;
          running_xor_next = running_xor ^ rx_byte;
          byte_count_next  = count_inc;
          if (count_inc >= frame_len) begin
            phase_next = PH_CHK;
          end
        end
        PH_CHK: begin
          phase_next        = PH_HUNT;
          q_push            = 1'b1;
          q_cmd.msg_id      = frame_id;
          q_cmd.payload_len = frame_len;
          if (running_xor != rx_byte) begin
            q_cmd.status = ST_CSUM;
          end else begin
            q_cmd.status = ST_OK;
            q_cmd.burst  = (frame_len != '0);
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Count payload bursts handed over but not yet fully sent.
  always_comb begin
    pending_next = pending;
    if (q_push && q_cmd.burst) begin
      pending_next = pending_next + PEND_W'(1);
    end
    if (burst_done) begin
      pending_next = pending_next - PEND_W'(1);
    end
  end

endmodule

@@ hw/rtl/slxd_queue.sv @@
// Short command FIFO between the parser and the result sequencer.
`timescale 1ns / 1ps

module slxd_queue
  import slxd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/slxd_back.sv @@
// Result sequencer: holds the payload buffer and sends reports and payload bursts.
`timescale 1ns / 1ps

module slxd_back
  import slxd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  store_wr_t        store_wr,
  input  logic             q_empty,
  input  cmd_t             q_head,
  output logic             q_pop,
  output logic             burst_done,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       msg_id,
  output logic [4:0]       payload_len,
  output logic [3:0]       byte_index,
  output logic [7:0]       payload_byte,
  output logic             byte_valid,
  output logic             last,
  output logic [1:0]       status
);

  logic [7:0]       store [MAX_PAYLOAD];
  logic             active;
  logic [IDX_W-1:0] idx;
  cmd_t             cur;
  logic             load;
  logic             burst_last;

  assign load       = !out_valid || out_ready;
  assign burst_last = ({1'b0, idx} + LEN_W'(1)) == cur.payload_len;
  assign q_pop      = load && !active && !q_empty;
  assign burst_done = load && active && burst_last;

  // Payload buffer, written by the parser.
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
  end

  // Burst control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      if (active) begin
        idx <= idx + IDX_W'(1);
        if (burst_last) begin
          active <= 1'b0;
        end
      end else if (!q_empty && q_head.burst) begin
        active <= 1'b1;
        idx    <= '0;
      end
    end
  end

  // Latch the burst command when it is taken from the queue.
  always_ff @(posedge clk) begin
    if (q_pop && q_head.burst) begin
      cur <= q_head;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= active || (!q_empty && !q_head.burst);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      if (active) begin
        msg_id       <= cur.msg_id;
        payload_len  <= 5'(cur.payload_len);
        byte_index   <= 4'(idx);
        payload_byte <= store[idx];
        byte_valid   <= 1'b1;
        last         <= burst_last;
        status       <= ST_OK;
      end else begin
        msg_id       <= q_head.msg_id;
        payload_len  <= 5'(q_head.payload_len);
        byte_index   <= '0;
        payload_byte <= '0;
        byte_valid   <= 1'b0;
        last         <= 1'b1;
        status       <= q_head.status;
      end
    end
  end

endmodule

@@ hw/rtl/sync_length_xor_message_deframer.sv @@
// Top level of the sync/length/XOR message deframer.
//
// Usage: received bytes enter one beat at a time on rx_byte with in_valid and
// in_ready. A frame is sync, length L, id, L payload bytes and an XOR checksum.
// Results leave on the out_* channel: one beat per payload byte of a good
// frame, or a single beat for a bad-sync run, a checksum mismatch, a length
// beyond 16 or an empty good frame. last marks the final beat of a group.
// The sync byte value is written on cfg_data with cfg_valid; cfg_ready is
// always high and the value resets to 0xA4.
// A byte that causes a report passes through the queue and output register;
// a payload burst also passes through the burst control, then sends one beat
// per cycle while out_ready is high. The parser takes one byte per cycle; the
// sustained rate is set by the serial source, and a payload byte of the next
// frame is held off while the previous burst is still queued or being sent.
// The two-entry command queue lets the parser run on while the output stalls;
// once it is full, in_ready drops until the receiver takes results.
// Reset (synchronous, active high) returns the parser to sync hunt and empties
// the queue and output register. No clearing pass is needed.
`timescale 1ns / 1ps

module sync_length_xor_message_deframer
  import slxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] msg_id,
  output logic [4:0] payload_len,
  output logic [3:0] byte_index,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [1:0] status
);

  logic      q_full;
  logic      q_push;
  cmd_t      q_cmd;
  logic      q_pop;
  logic      q_empty;
  cmd_t      q_head;
  logic      burst_done;
  store_wr_t store_wr;

  // Parser.
  slxd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .burst_done (burst_done),
    .store_wr   (store_wr)
  );

  // Command queue.
  slxd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Result sequencer.
  slxd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .store_wr     (store_wr),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .burst_done   (burst_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .msg_id       (msg_id),
    .payload_len  (payload_len),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status)
  );

endmodule

@@ test/deframe_check_pkg.sv @@
// Scoreboard for the deframer test: frame tracking and result beat checks.
`timescale 1ns / 1ps

package deframe_check_pkg;
  import slxd_pkg::*;

  // One result beat as the block should present it.
  typedef struct {
    logic [7:0] msg_id;
    logic [4:0] payload_len;
    logic [3:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
    status_t    status;
  } beat_t;

  class deframe_scoreboard;
    logic [7:0] sync_byte;
    phase_t     phase;
    logic [7:0] frame_len;
    logic [7:0] frame_id;
    logic [7:0] running_xor;
    logic [4:0] byte_count;
    bit         sync_error_sent;
    logic [7:0] payload_store [MAX_PAYLOAD];
    beat_t      awaited_beats [$];
    int         fails;

    function new();
      sync_byte       = SYNC_RESET;
      phase           = PH_HUNT;
      frame_len       = '0;
      frame_id        = '0;
      running_xor     = '0;
      byte_count      = '0;
      sync_error_sent = 1'b0;
      fails           = 0;
    endfunction

    function void set_sync(logic [7:0] value);
      sync_byte = value;
    endfunction

    function int pending();
      return awaited_beats.size();
    endfunction

    function void push_beat(logic [7:0] id, logic [4:0] len, logic [3:0] idx,
                            logic [7:0] data, logic valid, logic lst, status_t st);
      beat_t b;
      b.msg_id       = id;
      b.payload_len  = len;
      b.byte_index   = idx;
      b.payload_byte = data;
      b.byte_valid   = valid;
      b.last         = lst;
      b.status       = st;
      awaited_beats  = {awaited_beats, b};
    endfunction

    // Advance the frame parser by one accepted byte and queue the beats it causes.
    function void note_byte(logic [7:0] b);
      case (phase)
        PH_HUNT: begin
          if (b == sync_byte) begin
            sync_error_sent = 1'b0;
            running_xor     = b;
            byte_count      = '0;
            phase           = PH_LEN;
          end else if (!sync_error_sent) begin
            // Only the first stray byte of a run is reported.
            sync_error_sent = 1'b1;
            push_beat('0, '0, '0, '0, 1'b0, 1'b1, ST_SYNC);
          end
        end
        PH_LEN: begin
          frame_len   = b;
          running_xor = running_xor ^ b;
          if (b > MAX_PAYLOAD) begin
            phase = PH_HUNT;
            push_beat('0, '0, '0, '0, 1'b0, 1'b1, ST_LEN);
          end else begin
            phase = PH_ID;
          end
        end
        PH_ID: begin
          frame_id    = b;
          running_xor = running_xor ^ b;
          byte_count  = '0;
          if (frame_len == 0) phase = PH_CHK;
          else phase = PH_DATA;
        end
        PH_DATA: begin
          payload_store[byte_count[3:0]] = b;
          running_xor = running_xor ^ b;
          byte_count  = byte_count + 5'd1;
          if (byte_count >= frame_len) phase = PH_CHK;
        end
        PH_CHK: begin
          phase = PH_HUNT;
          if (running_xor != b) begin
            push_beat(frame_id, frame_len[4:0], '0, '0, 1'b0, 1'b1, ST_CSUM);
          end else if (frame_len == 0) begin
            push_beat(frame_id, '0, '0, '0, 1'b0, 1'b1, ST_OK);
          end else begin
            for (int i = 0; i < frame_len; i++)
              push_beat(frame_id, frame_len[4:0], 4'(i), payload_store[i], 1'b1,
                        (i + 1 == frame_len), ST_OK);
          end
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    // Compare one accepted result beat against the oldest outstanding one.
    function void check_beat(logic [7:0] id, logic [4:0] len, logic [3:0] idx,
                             logic [7:0] data, logic valid, logic lst, logic [1:0] st);
      beat_t e;
      if (awaited_beats.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d id %0d", st, id);
        fails++;
        return;
      end
      e = awaited_beats[0];
      awaited_beats.delete(0);
      compare_field("msg_id", e.msg_id, id);
      compare_field("payload_len", 8'(e.payload_len), 8'(len));
      compare_field("byte_index", 8'(e.byte_index), 8'(idx));
      compare_field("payload_byte", e.payload_byte, data);
      compare_field("byte_valid", 8'(e.byte_valid), 8'(valid));
      compare_field("last", 8'(e.last), 8'(lst));
      compare_field("status", 8'(e.status), 8'(st));
    endfunction
  endclass

endpackage

@@ test/sync_length_xor_message_deframer_test.sv @@
// Top-level test of the message deframer: random framed traffic, checked beat by beat.
`timescale 1ns / 1ps

module sync_length_xor_message_deframer_test;
  import slxd_pkg::*;
  import deframe_check_pkg::*;

  localparam int IDLE_PCT     = 31;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 8;
  localparam int DRAIN_TICKS  = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] msg_id;
  logic [4:0] payload_len;
  logic [3:0] byte_index;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;

  deframe_scoreboard sb = new();

  logic [7:0] cur_sync = SYNC_RESET;
  bit         calm = 1'b0;
  bit         hold_request = 1'b0;
  int         bytes_sent = 0;

  sync_length_xor_message_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .msg_id       (msg_id),
    .payload_len  (payload_len),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status)
  );

  always #4 clk = ~clk;

  // Result side: check each accepted beat, then pick the next ready value.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_beat(msg_id, payload_len, byte_index, payload_byte, byte_valid,
                      last, status);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        // Long hold-off so the command queue fills and the input backs up.
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles with no beat moving on any channel.
  initial begin
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one byte, with random gaps before it, and hold it until accepted.
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // A complete frame with random payload; a bad checksum flips some of its bits.
  task automatic send_frame(int len, logic [7:0] id, bit bad_sum);
    logic [7:0] sum;
    logic [7:0] d;
    sum = cur_sync ^ 8'(len) ^ id;
    send_byte(cur_sync);
    send_byte(8'(len));
    send_byte(id);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(255));
      sum = sum ^ d;
      send_byte(d);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
    send_byte(sum);
  endtask

  // Sync followed by a length beyond the buffer; the frame stops there.
  task automatic send_oversize(logic [7:0] len);
    send_byte(cur_sync);
    send_byte(len);
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Mostly well-formed frames, with broken frames and stray bytes mixed in.
  task automatic random_traffic(int count);
    int target;
    int pick;
    int len;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 74) begin
        len = $urandom_range(99);
        if (len < 10) len = MAX_PAYLOAD;
        else if (len < 20) len = 0;
        else len = $urandom_range(6, 1);
        send_frame(len, 8'($urandom_range(255)), $urandom_range(99) < 15);
      end else if (pick < 84) begin
        send_oversize(8'($urandom_range(255, MAX_PAYLOAD + 1)));
      end else begin
        send_noise($urandom_range(4, 1));
      end
    end
  endtask

  // Let every result drain, then write a new sync value.
  task automatic set_sync(logic [7:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_sync(value);
    cur_sync = value;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a stray run, empty frames, oversize lengths, short frames.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_frame(0, 8'hFF, 1'b0);
    send_frame(0, 8'h00, 1'b1);
    send_oversize(8'd17);
    send_oversize(8'd255);
    send_frame(1, 8'h00, 1'b0);
    send_frame(1, 8'h80, 1'b1);

    random_traffic(130);

    set_sync(8'h00);
    hold_request = 1'b1;
    random_traffic(120);

    set_sync(8'hFF);
    calm = 1'b1;
    random_traffic(60);
    calm = 1'b0;
    random_traffic(60);

    set_sync(8'($urandom_range(255)));
    random_traffic(60);

    // Drain and give late or extra beats a chance to show up.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (sb.fails == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
